### hw/rtl/arrival_ordered_instruction_queue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the arrival ordered instruction queue
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ARRIVAL_ORDERED_INSTRUCTION_QUEUE_DEFINES_SVH
`define ARRIVAL_ORDERED_INSTRUCTION_QUEUE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define AOIQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define AOIQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hw/rtl/aoiq_pkg.sv
// ----------------------------------------------------------------------------
// aoiq_pkg
// Opcodes, controller states and the command and status bundles shared by
// the queue controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package aoiq_pkg;

  // Operation codes carried by an input beat.
  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_TOP   = 3'd2,
    OP_LAST  = 3'd3,
    OP_READY = 3'd4,
    OP_SIZE  = 3'd5
  } op_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COUNT,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // capture the input beat
    logic exec;        // apply the operation to the cells
    logic count_step;  // retire one bit of the match vector
    logic load_out;    // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_count;     // captured operation is a count query
    logic match_empty;  // no match bits left to add up
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/aoiq_datapath.sv
// ----------------------------------------------------------------------------
// aoiq_datapath
// Row of tag and cycle cells with parallel compare, ordered or FIFO insert and
// front removal, plus the match counter and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arrival_ordered_instruction_queue_defines.svh"

module aoiq_datapath #(
  parameter int DEPTH      = 16,
  parameter int CYCLE_BITS = 32,
  parameter int TAG_BITS   = 8,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  aoiq_pkg::ctrl_cmd_t         cmd,
  output aoiq_pkg::dp_status_t        status,
  input  wire                         cfg_write_en,
  input  wire                         cfg_write_data,
  input  wire [2:0]                   in_opcode,
  input  wire [TAG_BITS-1:0]          in_record_tag,
  input  wire [CYCLE_BITS-1:0]        in_cycle_value,
  input  wire [CNT_W-1:0]             in_check_count,
  output logic                        out_popped_valid,
  output logic [TAG_BITS-1:0]         out_popped_tag,
  output logic [CNT_W-1:0]            out_match_count,
  output logic                        out_front_ready,
  output logic [CNT_W-1:0]            out_occupancy,
  output logic                        out_push_dropped
);

  localparam int LVLS = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Configuration and captured beat.
  logic                  mode_r;
  aoiq_pkg::op_t         op_r;
  logic [TAG_BITS-1:0]   tag_in_r;
  logic [CYCLE_BITS-1:0] cyc_in_r;
  logic [CNT_W-1:0]      chk_r;

  // Queue cells.
  logic [TAG_BITS-1:0]   cell_tag_r   [DEPTH];
  logic [CYCLE_BITS-1:0] cell_cyc_r   [DEPTH];
  logic [TAG_BITS-1:0]   cell_tag_nxt [DEPTH];
  logic [CYCLE_BITS-1:0] cell_cyc_nxt [DEPTH];
  logic [CNT_W-1:0]      count_r, count_nxt;

  // Counting and pending result.
  logic [DEPTH-1:0]      match_r, match_nxt;
  logic [CNT_W-1:0]      acc_r, acc_nxt;
  logic                  res_pv_r, res_fr_r, res_drop_r;
  logic [TAG_BITS-1:0]   res_tag_r;

  // Per-cell compare results.
  logic [DEPTH-1:0]      gt, eq, win_top, win_last, pfx, first;
  logic [CNT_W-1:0]      n_chk, last_lo;
  logic                  full, empty, do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = cmd.exec && (op_r == aoiq_pkg::OP_PUSH) && !full;
  assign do_pop  = cmd.exec && (op_r == aoiq_pkg::OP_POP) && !empty;
  assign n_chk   = (chk_r < count_r) ? chk_r : count_r;
  assign last_lo = count_r - n_chk;

  // Each cell compares its own cycle against the captured cycle. Empty slots
  // count as greater so that an insert with no greater entry lands at the back.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      eq[k]       = (cell_cyc_r[k] == cyc_in_r);
      gt[k]       = (CNT_W'(k) >= count_r) || (mode_r && (cyc_in_r < cell_cyc_r[k]));
      win_top[k]  = (CNT_W'(k) < n_chk);
      win_last[k] = (CNT_W'(k) >= last_lo) && (CNT_W'(k) < count_r);
    end
  end

  // Prefix OR over the greater-than flags marks the insert point and every
  // cell behind it; a log-depth tree keeps it shallow.
  always_comb begin
    pfx = gt;
    for (int l = 0; l < LVLS; l++) begin
      pfx = pfx | (pfx << (1 << l));
    end
    first = pfx & ~(pfx << 1);
  end

  // Cell update: insert shifts the tail back by one, pop shifts all forward.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      cell_tag_nxt[k] = cell_tag_r[k];
      cell_cyc_nxt[k] = cell_cyc_r[k];
      if (do_push) begin
        if (first[k]) begin
          cell_tag_nxt[k] = tag_in_r;
          cell_cyc_nxt[k] = cyc_in_r;
        end else if (pfx[k] && (k > 0)) begin
          cell_tag_nxt[k] = cell_tag_r[(k > 0) ? k - 1 : 0];
          cell_cyc_nxt[k] = cell_cyc_r[(k > 0) ? k - 1 : 0];
        end
      end else if (do_pop && (k < DEPTH - 1)) begin
        cell_tag_nxt[k] = cell_tag_r[(k < DEPTH - 1) ? k + 1 : k];
        cell_cyc_nxt[k] = cell_cyc_r[(k < DEPTH - 1) ? k + 1 : k];
      end
    end
  end

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // The match vector is loaded from the window, then drained one bit a cycle.
  always_comb begin
    match_nxt = match_r;
    acc_nxt   = acc_r;
    if (cmd.exec) begin
      acc_nxt = '0;
      case (op_r)
        aoiq_pkg::OP_TOP:  match_nxt = eq & win_top;
        aoiq_pkg::OP_LAST: match_nxt = eq & win_last;
        default:           match_nxt = '0;
      endcase
    end else if (cmd.count_step) begin
      match_nxt = match_r >> 1;
      acc_nxt   = acc_r + CNT_W'(match_r[0]);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      count_r <= '0;
    end else begin
      if (cfg_write_en) begin
        mode_r <= cfg_write_data;
      end
      count_r <= count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= aoiq_pkg::op_t'(in_opcode);
      tag_in_r <= in_record_tag;
      cyc_in_r <= in_cycle_value;
      chk_r    <= in_check_count;
    end
    for (int k = 0; k < DEPTH; k++) begin
      cell_tag_r[k] <= cell_tag_nxt[k];
      cell_cyc_r[k] <= cell_cyc_nxt[k];
    end
    match_r <= match_nxt;
    acc_r   <= acc_nxt;
    if (cmd.exec) begin
      res_pv_r   <= do_pop;
      res_tag_r  <= do_pop ? cell_tag_r[0] : '0;
      res_fr_r   <= (op_r == aoiq_pkg::OP_READY) && !empty && eq[0];
      res_drop_r <= (op_r == aoiq_pkg::OP_PUSH) && full;
    end
    if (cmd.load_out) begin
      out_popped_valid <= res_pv_r;
      out_popped_tag   <= res_tag_r;
      out_match_count  <= acc_r;
      out_front_ready  <= res_fr_r;
      out_occupancy    <= count_r;
      out_push_dropped <= res_drop_r;
    end
  end

  // Status for the controller.
  assign status.is_count    = (op_r == aoiq_pkg::OP_TOP) || (op_r == aoiq_pkg::OP_LAST);
  assign status.match_empty = (match_r == '0);

  `AOIQ_NEVER(a_count_in_range, count_r > FULL_CNT, "occupancy above depth")
  `AOIQ_ASSERT(a_push_grows, do_push |=> (count_r == $past(count_r) + 1'b1), "push lost")
  `AOIQ_ASSERT(a_pop_shrinks, do_pop |=> (count_r == $past(count_r) - 1'b1), "pop lost")

endmodule

`default_nettype wire

### hw/rtl/aoiq_ctrl.sv
// ----------------------------------------------------------------------------
// aoiq_ctrl
// State machine that sequences capture, execution, match counting and the
// hand-off of each result into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "arrival_ordered_instruction_queue_defines.svh"

module aoiq_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire                   out_stall,
  input  aoiq_pkg::dp_status_t  status,
  output aoiq_pkg::ctrl_cmd_t   cmd
);

  aoiq_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aoiq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      aoiq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = aoiq_pkg::ST_EXEC;
        end
      end
      aoiq_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.is_count ? aoiq_pkg::ST_COUNT : aoiq_pkg::ST_DONE;
      end
      aoiq_pkg::ST_COUNT: begin
        if (status.match_empty) begin
          state_nxt = aoiq_pkg::ST_DONE;
        end else begin
          cmd.count_step = 1'b1;
        end
      end
      aoiq_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = aoiq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = aoiq_pkg::ST_IDLE;
      end
    endcase
  end

  // Output beat valid: set on load, cleared once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  `AOIQ_NEVER(a_load_when_free, cmd.load_out && out_valid_r && out_stall, "result overwritten")
  `AOIQ_ASSERT(a_accept_exec, in_valid && !in_stall |=> state_r == aoiq_pkg::ST_EXEC, "beat dropped")
  `AOIQ_NEVER(a_open_only_idle, !in_stall && state_r != aoiq_pkg::ST_IDLE, "input open when busy")

endmodule

`default_nettype wire

### hw/rtl/arrival_ordered_instruction_queue.sv
// ----------------------------------------------------------------------------
// arrival_ordered_instruction_queue
// Queue of instruction tags held in arrival-cycle order, with push, pop and
// cycle-match queries, one result beat for every input beat.
// ----------------------------------------------------------------------------
// Input beats (in_valid / in_stall) carry an opcode, tag, cycle and check
// count; each produces exactly one result beat on out_valid / out_stall.
// cfg_write_en with cfg_write_data selects FIFO append (0) or ordered insert
// (1); write it only while the block is idle.
// One beat is handled at a time. Push, pop, ready and size raise out_valid
// after the accepting edge in this order: execute on the cell row, then output
// load. Count queries add a serial count between the two, stepping through
// the window up to the last matching cell, as set by the serial match counter.
// The next beat is accepted only once the controller is back in idle after
// the result is loaded, so a new beat never starts before the last is done.
// A finished result sits in the output register while the next beat is
// accepted; if the receiver stalls, the following result waits in the
// datapath until the output register frees up, and input stays stalled.
// Reset empties the queue, selects ordered mode and clears out_valid; cell
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module arrival_ordered_instruction_queue #(
  parameter int DEPTH      = 16,
  parameter int CYCLE_BITS = 32,
  parameter int TAG_BITS   = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_write_en,
  input  wire                          cfg_write_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [2:0]                    in_opcode,
  input  wire [TAG_BITS-1:0]           in_record_tag,
  input  wire [CYCLE_BITS-1:0]         in_cycle_value,
  input  wire [$clog2(DEPTH+1)-1:0]    in_check_count,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_popped_valid,
  output logic [TAG_BITS-1:0]          out_popped_tag,
  output logic [$clog2(DEPTH+1)-1:0]   out_match_count,
  output logic                         out_front_ready,
  output logic [$clog2(DEPTH+1)-1:0]   out_occupancy,
  output logic                         out_push_dropped
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  aoiq_pkg::ctrl_cmd_t  cmd;
  aoiq_pkg::dp_status_t status;

  // Sequencer.
  aoiq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Cell row and result registers.
  aoiq_datapath #(
    .DEPTH      (DEPTH),
    .CYCLE_BITS (CYCLE_BITS),
    .TAG_BITS   (TAG_BITS),
    .CNT_W      (CNT_W)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_opcode        (in_opcode),
    .in_record_tag    (in_record_tag),
    .in_cycle_value   (in_cycle_value),
    .in_check_count   (in_check_count),
    .out_popped_valid (out_popped_valid),
    .out_popped_tag   (out_popped_tag),
    .out_match_count  (out_match_count),
    .out_front_ready  (out_front_ready),
    .out_occupancy    (out_occupancy),
    .out_push_dropped (out_push_dropped)
  );

endmodule

`default_nettype wire

### tb/tb_arrival_ordered_instruction_queue.sv
// ----------------------------------------------------------------------------
// Testbench for arrival_ordered_instruction_queue
// Drives opcode beats through the valid/stall input channel and checks every
// result beat against an in-bench model of the tag queue or a row's typed
// result. A short table of directed beats comes first. Random phases follow,
// alternating between FIFO append and ordered insert. Both channels idle and
// stall at random. One long output hold-off per phase fills the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_arrival_ordered_instruction_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH           = 16;
  localparam int CYCLE_BITS      = 32;
  localparam int TAG_BITS        = 8;
  localparam int CNT_BITS        = $clog2(DEPTH + 1);
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int BEATS_PER_PHASE = 170;
  localparam int SETTLE_CYCLES   = 40;

  // Opcodes the block treats as no-ops.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Values carried by one result beat.
  typedef struct packed {
    logic                popped_valid;
    logic [TAG_BITS-1:0] popped_tag;
    logic [CNT_BITS-1:0] match_count;
    logic                front_ready;
    logic [CNT_BITS-1:0] occupancy;
    logic                push_dropped;
  } queue_result_t;

  // One input beat. Rows with a typed result are checked against that value.
  typedef struct {
    logic [2:0]            op;
    logic [TAG_BITS-1:0]   tag;
    logic [CYCLE_BITS-1:0] cyc;
    logic [CNT_BITS-1:0]   cnt;
    bit                    typed;
    queue_result_t         res;
  } beat_t;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  cfg_write_en     = 1'b0;
  logic                  cfg_write_data   = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [2:0]            in_opcode        = '0;
  logic [TAG_BITS-1:0]   in_record_tag    = '0;
  logic [CYCLE_BITS-1:0] in_cycle_value   = '0;
  logic [CNT_BITS-1:0]   in_check_count   = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic                  out_popped_valid;
  logic [TAG_BITS-1:0]   out_popped_tag;
  logic [CNT_BITS-1:0]   out_match_count;
  logic                  out_front_ready;
  logic [CNT_BITS-1:0]   out_occupancy;
  logic                  out_push_dropped;

  // Model of the queue: cells in front-to-back order and the mode register.
  logic [TAG_BITS-1:0]   cell_tag   [DEPTH];
  logic [CYCLE_BITS-1:0] cell_cycle [DEPTH];
  int                    held        = 0;
  bit                    sorted_mode = 1'b1;

  queue_result_t         pending_results[$];
  queue_result_t         oldest_result;
  int unsigned           mismatches   = 0;
  int unsigned           beats_sent   = 0;
  int unsigned           steady_beats = 0;
  logic [CYCLE_BITS-1:0] cycle_base   = '0;
  bit                    hold_off_req = 1'b0;

  arrival_ordered_instruction_queue #(
    .DEPTH      (DEPTH),
    .CYCLE_BITS (CYCLE_BITS),
    .TAG_BITS   (TAG_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_record_tag    (in_record_tag),
    .in_cycle_value   (in_cycle_value),
    .in_check_count   (in_check_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_valid (out_popped_valid),
    .out_popped_tag   (out_popped_tag),
    .out_match_count  (out_match_count),
    .out_front_ready  (out_front_ready),
    .out_occupancy    (out_occupancy),
    .out_push_dropped (out_push_dropped)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Applies one beat to the model queue and returns the result it produces.
  function automatic queue_result_t apply_to_queue(input logic [2:0] op,
      input logic [TAG_BITS-1:0] tag, input logic [CYCLE_BITS-1:0] cyc,
      input logic [CNT_BITS-1:0] cnt);
    queue_result_t r;
    int pos;
    int window;
    int lo;
    r = '0;
    case (op)
      aoiq_pkg::OP_PUSH: begin
        if (held == DEPTH) begin
          r.push_dropped = 1'b1;
        end else begin
          // Ordered insert goes ahead of the first strictly later cycle.
          pos = held;
          if (sorted_mode) begin
            for (int k = 0; k < held; k++)
              if (pos == held && cyc < cell_cycle[k]) pos = k;
          end
          for (int k = held; k > pos; k--) begin
            cell_tag[k]   = cell_tag[k-1];
            cell_cycle[k] = cell_cycle[k-1];
          end
          cell_tag[pos]   = tag;
          cell_cycle[pos] = cyc;
          held++;
        end
      end
      aoiq_pkg::OP_POP: begin
        if (held > 0) begin
          r.popped_valid = 1'b1;
          r.popped_tag   = cell_tag[0];
          for (int k = 1; k < held; k++) begin
            cell_tag[k-1]   = cell_tag[k];
            cell_cycle[k-1] = cell_cycle[k];
          end
          held--;
        end
      end
      aoiq_pkg::OP_TOP, aoiq_pkg::OP_LAST: begin
        // The window is clipped to the entries actually held.
        window = (int'(cnt) < held) ? int'(cnt) : held;
        lo     = (op == aoiq_pkg::OP_TOP) ? 0 : held - window;
        for (int k = lo; k < lo + window; k++)
          if (cell_cycle[k] == cyc) r.match_count++;
      end
      aoiq_pkg::OP_READY: begin
        r.front_ready = (held > 0) && (cell_cycle[0] == cyc);
      end
      default: begin
      end
    endcase
    r.occupancy = CNT_BITS'(held);
    return r;
  endfunction

  function automatic queue_result_t typed_result(input logic pv, input logic [TAG_BITS-1:0] tag,
      input logic [CNT_BITS-1:0] mc, input logic fr, input logic [CNT_BITS-1:0] occ,
      input logic drop);
    queue_result_t r;
    r.popped_valid = pv;
    r.popped_tag   = tag;
    r.match_count  = mc;
    r.front_ready  = fr;
    r.occupancy    = occ;
    r.push_dropped = drop;
    return r;
  endfunction

  function automatic beat_t row(input logic [2:0] op, input logic [TAG_BITS-1:0] tag,
      input logic [CYCLE_BITS-1:0] cyc, input logic [CNT_BITS-1:0] cnt,
      input bit typed = 1'b0, input queue_result_t res = '0);
    beat_t b;
    b.op    = op;
    b.tag   = tag;
    b.cyc   = cyc;
    b.cnt   = cnt;
    b.typed = typed;
    b.res   = res;
    return b;
  endfunction

  // Mostly pool cycles so that equal cycles and matches are common.
  function automatic logic [CYCLE_BITS-1:0] pick_cycle(input bit for_query);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (for_query && held > 0 && sel < 50) return cell_cycle[$urandom_range(0, held - 1)];
    if (sel < 60) return cycle_base + $urandom_range(0, 5);
    if (sel < 64) return '0;
    if (sel < 68) return '1;
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_opcode(input bit queries_only);
    int unsigned sel;
    sel = queries_only ? $urandom_range(52, 87) : $urandom_range(0, 99);
    if (sel < 30) return aoiq_pkg::OP_PUSH;
    if (sel < 52) return aoiq_pkg::OP_POP;
    if (sel < 64) return aoiq_pkg::OP_TOP;
    if (sel < 76) return aoiq_pkg::OP_LAST;
    if (sel < 88) return aoiq_pkg::OP_READY;
    if (sel < 94) return aoiq_pkg::OP_SIZE;
    if (sel < 97) return OP_SPARE_6;
    return OP_SPARE_7;
  endfunction

  // Offers one beat, waits for acceptance, records the expected result and
  // then idles the input for a random gap.
  task automatic send_beat(input beat_t b);
    queue_result_t predicted;
    int unsigned sel;
    int unsigned gap;
    in_valid       <= 1'b1;
    in_opcode      <= b.op;
    in_record_tag  <= b.tag;
    in_cycle_value <= b.cyc;
    in_check_count <= b.cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_to_queue(b.op, b.tag, b.cyc, b.cnt);
    pending_results.insert(pending_results.size(), b.typed ? b.res : predicted);
    beats_sent++;

    // Mostly short gaps, a few long ones, and runs of back-to-back beats.
    gap = 0;
    if (steady_beats > 0) begin
      steady_beats--;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 45) gap = 0;
      else if (sel < 80) gap = $urandom_range(1, 3);
      else if (sel < 93) gap = $urandom_range(4, 12);
      else if (sel < 97) gap = $urandom_range(20, 40);
      else steady_beats = $urandom_range(30, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input logic [2:0] op);
    logic [CNT_BITS-1:0] cnt;
    cnt = ($urandom_range(0, 99) < 80) ? CNT_BITS'($urandom_range(0, DEPTH))
                                       : CNT_BITS'($urandom_range(0, 31));
    send_beat(row(op, TAG_BITS'($urandom_range(0, 255)),
                  pick_cycle(op != aoiq_pkg::OP_PUSH), cnt));
  endtask

  // Pushes until at least two pushes have been dropped on a full queue.
  task automatic fill_queue();
    repeat (DEPTH + 2 - held) send_random(aoiq_pkg::OP_PUSH);
  endtask

  // Lowers valid and waits until every expected result beat has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_mode(input bit mode);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= mode;
    @(posedge clk);
    sorted_mode = mode;
    cfg_write_en <= 1'b0;
  endtask

  // Random traffic built from well-formed sequences with random content.
  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int unsigned kind;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind < 11) repeat (8) send_random(pick_opcode(1'b0));
      else if (kind < 14) fill_queue();
      else if (kind < 16) repeat (held + 1) send_random(aoiq_pkg::OP_POP);
      else if (kind < 19) repeat (6) send_random(pick_opcode(1'b1));
      else drain_results();
    end
  endtask

  // Stimulus: reset, directed table, then random phases across both modes.
  initial begin
    beat_t rows[$];
    bit    phase_modes[4];
    phase_modes = '{1'b0, 1'b1, 1'b0, 1'b1};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue after reset, then extreme cycles and equal-cycle pushes.
    rows.insert(rows.size(), row(aoiq_pkg::OP_POP, 8'h00, '0, 0, 1,
                                 typed_result(0, 0, 0, 0, 0, 0)));
    rows.insert(rows.size(), row(aoiq_pkg::OP_READY, 8'hFF, '0, 0, 1,
                                 typed_result(0, 0, 0, 0, 0, 0)));
    rows.insert(rows.size(), row(aoiq_pkg::OP_TOP, 8'h00, '0, 16, 1,
                                 typed_result(0, 0, 0, 0, 0, 0)));
    rows.insert(rows.size(), row(aoiq_pkg::OP_LAST, 8'h00, '1, 31, 1,
                                 typed_result(0, 0, 0, 0, 0, 0)));
    rows.insert(rows.size(), row(aoiq_pkg::OP_SIZE, 8'h00, '0, 0, 1,
                                 typed_result(0, 0, 0, 0, 0, 0)));
    rows.insert(rows.size(), row(aoiq_pkg::OP_PUSH, 8'hFF, '1, 31, 1,
                                 typed_result(0, 0, 0, 0, 1, 0)));
    rows.insert(rows.size(), row(aoiq_pkg::OP_PUSH, 8'h00, '0, 0, 1,
                                 typed_result(0, 0, 0, 0, 2, 0)));
    rows.insert(rows.size(), row(aoiq_pkg::OP_PUSH, 8'hA5, 32'h8000_0000, 0, 1,
                                 typed_result(0, 0, 0, 0, 3, 0)));
    rows.insert(rows.size(), row(aoiq_pkg::OP_PUSH, 8'h5A, 32'h8000_0000, 0, 1,
                                 typed_result(0, 0, 0, 0, 4, 0)));
    rows.insert(rows.size(), row(aoiq_pkg::OP_READY, 8'h00, '0, 0));
    rows.insert(rows.size(), row(aoiq_pkg::OP_READY, 8'h00, 32'h0000_0001, 0));
    rows.insert(rows.size(), row(aoiq_pkg::OP_TOP, 8'h00, '0, 0, 1,
                                 typed_result(0, 0, 0, 0, 4, 0)));
    rows.insert(rows.size(), row(aoiq_pkg::OP_TOP, 8'h00, 32'h8000_0000, 31));
    rows.insert(rows.size(), row(aoiq_pkg::OP_LAST, 8'h00, 32'h8000_0000, 2));
    rows.insert(rows.size(), row(aoiq_pkg::OP_LAST, 8'h00, '1, 1));
    rows.insert(rows.size(), row(aoiq_pkg::OP_LAST, 8'h00, 32'h8000_0001, 16));
    rows.insert(rows.size(), row(OP_SPARE_6, 8'hFF, '1, 31));
    rows.insert(rows.size(), row(OP_SPARE_7, 8'h00, '0, 0));
    rows.insert(rows.size(), row(aoiq_pkg::OP_POP, 8'h00, '0, 0));
    rows.insert(rows.size(), row(aoiq_pkg::OP_POP, 8'h00, '0, 0));
    rows.insert(rows.size(), row(aoiq_pkg::OP_POP, 8'h00, '0, 0));
    rows.insert(rows.size(), row(aoiq_pkg::OP_POP, 8'h00, '0, 0));
    rows.insert(rows.size(), row(aoiq_pkg::OP_POP, 8'h00, '0, 0, 1,
                                 typed_result(0, 0, 0, 0, 0, 0)));
    foreach (rows[i]) send_beat(rows[i]);

    // Each phase opens with a long output hold-off while the queue fills.
    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      cycle_base   = $urandom;
      hold_off_req = 1'b1;
      fill_queue();
      run_random(BEATS_PER_PHASE);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Output stall pattern, with a long counted hold-off on request.
  initial begin
    int unsigned sel;
    int unsigned span;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 8);
        end else if (sel < 85) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else if (sel < 95) begin
          out_stall <= 1'b1;
          span = $urandom_range(4, 20);
        end else begin
          out_stall <= 1'b0;
          span = $urandom_range(30, 60);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, expected nothing, actual occupancy %0d",
                 $time, out_occupancy);
      end else begin
        oldest_result = pending_results[0];
        pending_results.delete(0);
        check_field("popped_valid", 32'(oldest_result.popped_valid), 32'(out_popped_valid));
        check_field("popped_tag",   32'(oldest_result.popped_tag),   32'(out_popped_tag));
        check_field("match_count",  32'(oldest_result.match_count),  32'(out_match_count));
        check_field("front_ready",  32'(oldest_result.front_ready),  32'(out_front_ready));
        check_field("occupancy",    32'(oldest_result.occupancy),    32'(out_occupancy));
        check_field("push_dropped", 32'(oldest_result.push_dropped), 32'(out_push_dropped));
      end
    end
  end

  // Hard limit on run time, far above the slowest correct run.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/aoiq_pkg.sv
hw/rtl/aoiq_datapath.sv
hw/rtl/aoiq_ctrl.sv
hw/rtl/arrival_ordered_instruction_queue.sv
tb/tb_arrival_ordered_instruction_queue.sv
